>>> hdl/ffkc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ffkc_pkg;

  localparam logic [1:0] KEY_DIGIT  = 2'd0;
  localparam logic [1:0] KEY_OPER   = 2'd1;
  localparam logic [1:0] KEY_EQUALS = 2'd2;
  localparam logic [1:0] KEY_CLEAR  = 2'd3;

  localparam logic [2:0] OP_NONE = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;

  localparam logic [3:0] DP_NOP      = 4'd0;
  localparam logic [3:0] DP_DIGIT    = 4'd1;
  localparam logic [3:0] DP_OPER     = 4'd2;
  localparam logic [3:0] DP_CLEAR    = 4'd3;
  localparam logic [3:0] DP_ADD      = 4'd4;
  localparam logic [3:0] DP_SUB      = 4'd5;
  localparam logic [3:0] DP_MUL_INIT = 4'd6;
  localparam logic [3:0] DP_MUL_STEP = 4'd7;
  localparam logic [3:0] DP_DIV_INIT = 4'd8;
  localparam logic [3:0] DP_DIV_STEP = 4'd9;
  localparam logic [3:0] DP_TAKE_P   = 4'd10;
  localparam logic [3:0] DP_TAKE_Q   = 4'd11;
  localparam logic [3:0] DP_DZ       = 4'd12;

  localparam logic [2:0] C_NEXT    = 3'd0;
  localparam logic [2:0] C_ALWAYS  = 3'd1;
  localparam logic [2:0] C_NOPEND  = 3'd2;
  localparam logic [2:0] C_ISADD   = 3'd3;
  localparam logic [2:0] C_ISSUB   = 3'd4;
  localparam logic [2:0] C_ISMUL   = 3'd5;
  localparam logic [2:0] C_DIVZERO = 3'd6;
  localparam logic [2:0] C_MORE    = 3'd7;

  localparam int UPC_W = 5;

  localparam logic [UPC_W-1:0] A_DIGIT    = 5'd0;
  localparam logic [UPC_W-1:0] A_OPER     = 5'd1;
  localparam logic [UPC_W-1:0] A_CLEAR    = 5'd2;
  localparam logic [UPC_W-1:0] A_EQUALS   = 5'd3;
  localparam logic [UPC_W-1:0] A_TEST_ADD = 5'd4;
  localparam logic [UPC_W-1:0] A_TEST_SUB = 5'd5;
  localparam logic [UPC_W-1:0] A_TEST_MUL = 5'd6;
  localparam logic [UPC_W-1:0] A_TEST_DZ  = 5'd7;
  localparam logic [UPC_W-1:0] A_DIV_INIT = 5'd8;
  localparam logic [UPC_W-1:0] A_DIV_LOOP = 5'd9;
  localparam logic [UPC_W-1:0] A_TAKE_Q   = 5'd10;
  localparam logic [UPC_W-1:0] A_ADD      = 5'd11;
  localparam logic [UPC_W-1:0] A_SUB      = 5'd12;
  localparam logic [UPC_W-1:0] A_MUL_INIT = 5'd13;
  localparam logic [UPC_W-1:0] A_MUL_LOOP = 5'd14;
  localparam logic [UPC_W-1:0] A_TAKE_P   = 5'd15;
  localparam logic [UPC_W-1:0] A_DZ       = 5'd16;
  localparam logic [UPC_W-1:0] A_FINISH   = 5'd17;
  localparam logic [UPC_W-1:0] A_END      = 5'd18;

  typedef struct packed {
    logic [1:0] req_type;
    logic [3:0] digit;
    logic [1:0] operation;
  } key_t;

  typedef struct packed {
    logic        result_valid;
    logic [15:0] result;
    logic        div_by_zero;
  } answer_t;

  typedef struct packed {
    logic [3:0]       op;
    logic [2:0]       cond;
    logic [UPC_W-1:0] target;
    logic             emit;
    logic             last;
  } ctrl_t;

  typedef struct packed {
    logic pend_none;
    logic is_add;
    logic is_sub;
    logic is_mul;
    logic div_zero;
    logic more;
  } flags_t;

  function automatic ctrl_t urom(input logic [UPC_W-1:0] addr);
    ctrl_t cw;
    case (addr)
      A_DIGIT:    cw = '{DP_DIGIT,    C_NEXT,    A_END,      1'b0, 1'b1};
      A_OPER:     cw = '{DP_OPER,     C_NEXT,    A_END,      1'b0, 1'b1};
      A_CLEAR:    cw = '{DP_CLEAR,    C_NEXT,    A_END,      1'b0, 1'b1};
      A_EQUALS:   cw = '{DP_NOP,      C_NOPEND,  A_END,      1'b0, 1'b0};
      A_END:      cw = '{DP_NOP,      C_NEXT,    A_END,      1'b0, 1'b1};
      A_TEST_ADD: cw = '{DP_NOP,      C_ISADD,   A_ADD,      1'b0, 1'b0};
      A_TEST_SUB: cw = '{DP_NOP,      C_ISSUB,   A_SUB,      1'b0, 1'b0};
      A_TEST_MUL: cw = '{DP_NOP,      C_ISMUL,   A_MUL_INIT, 1'b0, 1'b0};
      A_TEST_DZ:  cw = '{DP_NOP,      C_DIVZERO, A_DZ,       1'b0, 1'b0};
      A_DIV_INIT: cw = '{DP_DIV_INIT, C_NEXT,    A_END,      1'b0, 1'b0};
      A_DIV_LOOP: cw = '{DP_DIV_STEP, C_MORE,    A_DIV_LOOP, 1'b0, 1'b0};
      A_TAKE_Q:   cw = '{DP_TAKE_Q,   C_ALWAYS,  A_FINISH,   1'b0, 1'b0};
      A_ADD:      cw = '{DP_ADD,      C_ALWAYS,  A_FINISH,   1'b0, 1'b0};
      A_SUB:      cw = '{DP_SUB,      C_ALWAYS,  A_FINISH,   1'b0, 1'b0};
      A_MUL_INIT: cw = '{DP_MUL_INIT, C_NEXT,    A_END,      1'b0, 1'b0};
      A_MUL_LOOP: cw = '{DP_MUL_STEP, C_MORE,    A_MUL_LOOP, 1'b0, 1'b0};
      A_TAKE_P:   cw = '{DP_TAKE_P,   C_ALWAYS,  A_FINISH,   1'b0, 1'b0};
      A_DZ:       cw = '{DP_DZ,       C_NEXT,    A_END,      1'b0, 1'b0};
      A_FINISH:   cw = '{DP_CLEAR,    C_NEXT,    A_END,      1'b1, 1'b1};
      default:    cw = '{DP_NOP,      C_NEXT,    A_END,      1'b0, 1'b1};
    endcase
    return cw;
  endfunction

endpackage
`default_nettype wire

>>> hdl/ffkc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module ffkc_datapath #(
  parameter int DATA_WIDTH = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  key_accept,
  input  wire ffkc_pkg::key_t        key,
  input  wire logic                  exec,
  input  wire logic [3:0]            op,
  output ffkc_pkg::flags_t           flags,
  output logic [DATA_WIDTH-1:0]      res,
  output logic                       dz
);
  import ffkc_pkg::*;

  localparam int CW = $clog2(DATA_WIDTH);

  logic [DATA_WIDTH-1:0] entry;
  logic [DATA_WIDTH-1:0] opnd;
  logic [2:0]            pop;
  logic [3:0]            key_digit;
  logic [1:0]            key_op;
  logic [DATA_WIDTH-1:0] acc;
  logic [DATA_WIDTH-1:0] shq;
  logic [DATA_WIDTH-1:0] mcand;
  logic [CW-1:0]         cnt;
  logic [DATA_WIDTH:0]   shifted;
  logic [DATA_WIDTH:0]   diff;
  logic                  fits;
  logic [DATA_WIDTH-1:0] entry_next;

  assign shifted    = {acc, shq[DATA_WIDTH-1]};
  assign diff       = shifted - {1'b0, entry};
  assign fits       = shifted >= {1'b0, entry};
  assign entry_next = (entry << 3) + (entry << 1) + DATA_WIDTH'(key_digit);

  assign flags.pend_none = (pop == OP_NONE);
  assign flags.is_add    = (pop == OP_ADD);
  assign flags.is_sub    = (pop == OP_SUB);
  assign flags.is_mul    = (pop == OP_MUL);
  assign flags.div_zero  = (entry == '0);
  assign flags.more      = (cnt != CW'(DATA_WIDTH - 1));

  always_ff @(posedge clk) begin
    if (key_accept) begin
      key_digit <= key.digit;
      key_op    <= key.operation;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
      opnd  <= '0;
      pop   <= OP_NONE;
    end else if (exec) begin
      case (op)
        DP_DIGIT: begin
          if (key_digit <= 4'd9) begin
            entry <= entry_next;
          end
        end
        DP_OPER: begin
          opnd  <= entry;
          pop   <= {1'b0, key_op} + 3'd1;
          entry <= '0;
        end
        DP_CLEAR: begin
          entry <= '0;
          opnd  <= '0;
          pop   <= OP_NONE;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      case (op)
        DP_ADD: begin
          res <= opnd + entry;
          dz  <= 1'b0;
        end
        DP_SUB: begin
          res <= opnd - entry;
          dz  <= 1'b0;
        end
        DP_MUL_INIT: begin
          acc   <= '0;
          shq   <= entry;
          mcand <= opnd;
          cnt   <= '0;
        end
        DP_MUL_STEP: begin
          acc   <= acc + (shq[0] ? mcand : '0);
          shq   <= shq >> 1;
          mcand <= mcand << 1;
          cnt   <= cnt + 1'b1;
        end
        DP_DIV_INIT: begin
          acc <= '0;
          shq <= opnd;
          cnt <= '0;
        end
        DP_DIV_STEP: begin
          acc <= fits ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
          shq <= {shq[DATA_WIDTH-2:0], fits};
          cnt <= cnt + 1'b1;
        end
        DP_TAKE_P: begin
          res <= acc;
          dz  <= 1'b0;
        end
        DP_TAKE_Q: begin
          res <= shq;
          dz  <= 1'b0;
        end
        DP_DZ: begin
          res <= '0;
          dz  <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> hdl/ffkc_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
module ffkc_sequencer (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             key_accept,
  input  wire logic [1:0]       req_type,
  input  wire ffkc_pkg::flags_t flags,
  input  wire logic             answer_busy,
  output logic                  busy,
  output logic                  exec,
  output logic                  emit,
  output logic [3:0]            op
);
  import ffkc_pkg::*;

  logic [UPC_W-1:0] upc;
  logic [UPC_W-1:0] start;
  ctrl_t            ctrl;
  logic             stall;
  logic             take;

  assign ctrl  = urom(upc);
  assign stall = ctrl.emit && answer_busy;
  assign exec  = busy && !stall;
  assign emit  = exec && ctrl.emit;
  assign op    = ctrl.op;

  always_comb begin
    case (req_type)
      KEY_DIGIT:  start = A_DIGIT;
      KEY_OPER:   start = A_OPER;
      KEY_EQUALS: start = A_EQUALS;
      default:    start = A_CLEAR;
    endcase
  end

  always_comb begin
    case (ctrl.cond)
      C_ALWAYS:  take = 1'b1;
      C_NOPEND:  take = flags.pend_none;
      C_ISADD:   take = flags.is_add;
      C_ISSUB:   take = flags.is_sub;
      C_ISMUL:   take = flags.is_mul;
      C_DIVZERO: take = flags.div_zero;
      C_MORE:    take = flags.more;
      default:   take = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      upc  <= A_END;
    end else if (!busy) begin
      if (key_accept) begin
        busy <= 1'b1;
        upc  <= start;
      end
    end else if (exec) begin
      if (ctrl.last) begin
        busy <= 1'b0;
      end else if (take) begin
        upc <= ctrl.target;
      end else begin
        upc <= upc + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/four_function_key_calculator.sv
// Channel  Signals                          Moves
// key      key_valid, key_ready, key        one decoded key per item
// answer   answer_valid, answer_ready,      one result item per equals
//          answer                           with a pending operation
//
// A digit, operator or clear key runs a microcode word that ends the sequence.
// Equals with a pending operation tests for add, subtract, multiply and divide by
// zero in that order; multiply and divide then run the one-bit-per-step shift-add
// and restoring-divide loops of the microcode. With nothing pending, equals ends
// without an answer.
// Reset clears the entry, operand, pending operation and the answer valid flag.
// A held answer stalls only the final microcode step of the next equals.
`timescale 1ns / 1ps
`default_nettype none
module four_function_key_calculator #(
  parameter int DATA_WIDTH = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              key_valid,
  output logic                   key_ready,
  input  wire ffkc_pkg::key_t    key,
  output logic                   answer_valid,
  input  wire logic              answer_ready,
  output ffkc_pkg::answer_t      answer
);
  import ffkc_pkg::*;

  logic                  key_accept;
  logic                  busy;
  logic                  exec;
  logic                  emit;
  logic [3:0]            op;
  flags_t                flags;
  logic [DATA_WIDTH-1:0] res;
  logic                  dz;
  logic                  answer_busy;

  assign key_ready   = !busy;
  assign key_accept  = key_valid && key_ready;
  assign answer_busy = answer_valid && !answer_ready;

  ffkc_sequencer u_seq (
    .clk         (clk),
    .rst         (rst),
    .key_accept  (key_accept),
    .req_type    (key.req_type),
    .flags       (flags),
    .answer_busy (answer_busy),
    .busy        (busy),
    .exec        (exec),
    .emit        (emit),
    .op          (op)
  );

  ffkc_datapath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .key_accept (key_accept),
    .key        (key),
    .exec       (exec),
    .op         (op),
    .flags      (flags),
    .res        (res),
    .dz         (dz)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      answer_valid <= 1'b0;
    end else if (emit) begin
      answer_valid <= 1'b1;
    end else if (answer_ready) begin
      answer_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      answer.result_valid <= 1'b1;
      answer.result       <= 16'(res);
      answer.div_by_zero  <= dz;
    end
  end

endmodule
`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import ffkc_pkg::*;

  localparam logic [1:0] SEL_ADD = 2'd0;
  localparam logic [1:0] SEL_SUB = 2'd1;
  localparam logic [1:0] SEL_MUL = 2'd2;
  localparam logic [1:0] SEL_DIV = 2'd3;
  localparam logic [3:0] MAX_DIGIT = 4'd9;
  localparam int RANDOM_KEYS = 1450;
  localparam int DRAIN_CYCLES = 40;

  class calc_model;
    answer_t expected_answers[$];
    logic [15:0] entry;
    logic [15:0] first_op;
    logic [2:0] pend_op;
    int errors;

    function new();
      errors = 0;
      clear_all();
    endfunction

    function void clear_all();
      entry = '0;
      first_op = '0;
      pend_op = OP_NONE;
    endfunction

    function void press_key(key_t k);
      answer_t a;
      case (k.req_type)
        KEY_DIGIT: begin
          if (k.digit <= MAX_DIGIT) entry = entry * 16'd10 + {12'd0, k.digit};
        end
        KEY_OPER: begin
          first_op = entry;
          entry = '0;
          case (k.operation)
            SEL_ADD: pend_op = OP_ADD;
            SEL_SUB: pend_op = OP_SUB;
            SEL_MUL: pend_op = OP_MUL;
            default: pend_op = OP_DIV;
          endcase
        end
        KEY_CLEAR: clear_all();
        default: begin
          if (pend_op != OP_NONE) begin
            a.result_valid = 1'b1;
            a.div_by_zero = 1'b0;
            case (pend_op)
              OP_ADD: a.result = first_op + entry;
              OP_SUB: a.result = first_op - entry;
              OP_MUL: a.result = first_op * entry;
              default: begin
                if (entry == 16'd0) begin
                  a.result = '0;
                  a.div_by_zero = 1'b1;
                end else begin
                  a.result = first_op / entry;
                end
              end
            endcase
            expected_answers.push_back(a);
            clear_all();
          end
        end
      endcase
    endfunction

    function void compare_answer(answer_t got);
      answer_t want;
      if (expected_answers.size() == 0) begin
        $error("unexpected answer: result %0d div_by_zero %0d", got.result, got.div_by_zero);
        errors++;
        return;
      end
      want = expected_answers.pop_front();
      if (got.result_valid !== want.result_valid) begin
        $error("result_valid: expected %0d, got %0d", want.result_valid, got.result_valid);
        errors++;
      end
      if (got.result !== want.result) begin
        $error("result: expected %0d, got %0d", want.result, got.result);
        errors++;
      end
      if (got.div_by_zero !== want.div_by_zero) begin
        $error("div_by_zero: expected %0d, got %0d", want.div_by_zero, got.div_by_zero);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic key_valid = 1'b0;
  logic key_ready;
  key_t key = '0;
  logic answer_valid;
  logic answer_ready = 1'b0;
  answer_t answer;

  calc_model calc = new();
  int keys_counted = 0;
  int burst_left = 0;
  int stall_mode = 0;
  logic [15:0] cyc = '0;

  four_function_key_calculator dut (
    .clk(clk),
    .rst(rst),
    .key_valid(key_valid),
    .key_ready(key_ready),
    .key(key),
    .answer_valid(answer_valid),
    .answer_ready(answer_ready),
    .answer(answer)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (rst) begin
      answer_ready <= 1'b0;
      cyc <= '0;
    end else begin
      cyc <= cyc + 16'd1;
      if (cyc[6:0] == 7'd0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: answer_ready <= 1'b1;
        1: answer_ready <= 1'($urandom_range(0, 1));
        2: answer_ready <= (cyc[1:0] == 2'd0);
        default: answer_ready <= (cyc[3:0] >= 4'd12);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && answer_valid && answer_ready) calc.compare_answer(answer);
  end

  function automatic key_t make_key(logic [1:0] kind, logic [3:0] dig, logic [1:0] sel);
    key_t k;
    k.req_type = kind;
    k.digit = dig;
    k.operation = sel;
    return k;
  endfunction

  task automatic send_key(key_t k);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 2) != 0) gap = $urandom_range(1, 12);
    end
    if (gap > 0) begin
      key_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    key <= k;
    key_valid <= 1'b1;
    do @(posedge clk); while (!key_ready);
    burst_left--;
    calc.press_key(k);
    if (!(k.req_type == KEY_DIGIT && k.digit > MAX_DIGIT)) keys_counted++;
  endtask

  task automatic press_digit(logic [3:0] d);
    send_key(make_key(KEY_DIGIT, d, 2'($urandom)));
  endtask

  task automatic press_oper(logic [1:0] sel);
    send_key(make_key(KEY_OPER, 4'($urandom), sel));
  endtask

  task automatic press(logic [1:0] kind);
    send_key(make_key(kind, 4'($urandom), 2'($urandom)));
  endtask

  task automatic type_number(int n);
    repeat (n) press_digit(4'($urandom_range(0, 9)));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    press(KEY_CLEAR);
    press_digit(4'd15);
    press(KEY_EQUALS);
    press_digit(4'd6);
    press_digit(4'd5);
    press_digit(4'd5);
    press_digit(4'd3);
    press_digit(4'd5);
    press_oper(SEL_MUL);
    press_digit(4'd9);
    press_digit(4'd9);
    press_oper(SEL_ADD);
    press_digit(4'd1);
    press(KEY_EQUALS);
    press_oper(SEL_SUB);
    press_digit(4'd7);
    press(KEY_EQUALS);
    press_digit(4'd9);
    press_oper(SEL_DIV);
    press(KEY_EQUALS);
    press_digit(4'd8);
    press_digit(4'd10);
    press_oper(SEL_DIV);
    press_digit(4'd3);
    press(KEY_EQUALS);

    keys_counted = 0;
    while (keys_counted < RANDOM_KEYS) begin
      if ($urandom_range(0, 4) != 0) begin
        if ($urandom_range(0, 9) == 0) press(KEY_CLEAR);
        type_number($urandom_range(0, 6));
        press_oper(2'($urandom));
        if ($urandom_range(0, 7) == 0) begin
          type_number($urandom_range(0, 3));
          press_oper(2'($urandom));
        end
        type_number($urandom_range(0, 6));
        if ($urandom_range(0, 9) != 0) press(KEY_EQUALS);
      end else begin
        repeat ($urandom_range(1, 4)) send_key(key_t'(8'($urandom)));
      end
    end
    key_valid <= 1'b0;

    while (calc.expected_answers.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (calc.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> four_function_key_calculator.f
hdl/ffkc_pkg.sv
hdl/ffkc_datapath.sv
hdl/ffkc_sequencer.sv
hdl/four_function_key_calculator.sv
test/testbench.sv
